[design/etrs_pkg.sv]
// Package for the Euler TRS model matrix block: widths, CORDIC constants,
// fixed-point helper functions. No dependencies.
package etrs_pkg;

  localparam int unsigned CordicStagesDef = 16;
  localparam int unsigned FracBitsDef     = 16;
  localparam int unsigned AtanLen         = 30;
  localparam int unsigned Deg64Turn       = 23040;
  localparam int unsigned AngW            = 16;
  localparam int unsigned DataW           = 32;
  localparam int unsigned CordW           = 34;
  localparam logic signed [CordW-1:0] GainQ30 = 34'sd652032874;

  typedef logic signed [CordW-1:0] cord_t;

  typedef struct packed {
    cord_t      x;
    cord_t      y;
    cord_t      z;
    logic [1:0] q;
  } cord_lane_t;

  function automatic cord_t atan_lut(input logic [4:0] idx);
    cord_t v;
    unique case (idx)
      5'd0:  v = 34'sd536870912;
      5'd1:  v = 34'sd316933406;
      5'd2:  v = 34'sd167458907;
      5'd3:  v = 34'sd85004756;
      5'd4:  v = 34'sd42667331;
      5'd5:  v = 34'sd21354465;
      5'd6:  v = 34'sd10679838;
      5'd7:  v = 34'sd5340245;
      5'd8:  v = 34'sd2670163;
      5'd9:  v = 34'sd1335087;
      5'd10: v = 34'sd667544;
      5'd11: v = 34'sd333772;
      5'd12: v = 34'sd166886;
      5'd13: v = 34'sd83443;
      5'd14: v = 34'sd41722;
      5'd15: v = 34'sd20861;
      5'd16: v = 34'sd10430;
      5'd17: v = 34'sd5215;
      5'd18: v = 34'sd2608;
      5'd19: v = 34'sd1304;
      5'd20: v = 34'sd652;
      5'd21: v = 34'sd326;
      5'd22: v = 34'sd163;
      5'd23: v = 34'sd81;
      5'd24: v = 34'sd41;
      5'd25: v = 34'sd20;
      5'd26: v = 34'sd10;
      5'd27: v = 34'sd5;
      5'd28: v = 34'sd3;
      5'd29: v = 34'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [DataW-1:0] sat32(input logic signed [65:0] v);
    logic signed [DataW-1:0] r;
    if (v > 66'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -66'sh0_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[DataW-1:0];
    end
    return r;
  endfunction

endpackage

[design/etrs_reduce.sv]
// Angle reduction stage: angle modulo one turn and phase in 2^32-per-turn units.
// Two registered steps. Depends on etrs_pkg.
module etrs_reduce (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic signed [15:0]          angle_i,
  output etrs_pkg::cord_lane_t        lane_o
);
  import etrs_pkg::*;

  logic [14:0] m_q;
  logic [14:0] m_d;
  logic signed [16:0] a_ext;
  logic [54:0] prod;
  logic [31:0] p;

  // m*2^32/23040 = m*2^23/45, taken as (m*ceil(2^46/45)) >> 23
  localparam logic [40:0] Recip = 41'd1563749870615;

  always_comb begin
    a_ext = 17'(angle_i);
    if (a_ext < 0) begin
      a_ext = a_ext + 17'sd23040;
    end
    if (a_ext < 0) begin
      a_ext = a_ext + 17'sd23040;
    end
    if (a_ext >= 17'sd23040) begin
      a_ext = a_ext - 17'sd23040;
    end
    m_d = a_ext[14:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q <= m_d;
    end
  end

  assign prod = 55'(m_q) * 55'(Recip);
  assign p    = prod[54:23];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_o.x <= GainQ30;
      lane_o.y <= '0;
      lane_o.z <= cord_t'({2'b00, p[29:0]});
      lane_o.q <= p[31:30];
    end
  end

endmodule

[design/etrs_cordic_cell.sv]
// One CORDIC rotation cell for three lanes plus carried payload.
// Depends on etrs_pkg.
module etrs_cordic_cell #(
  parameter int unsigned Stage = 0,
  parameter int unsigned PayW  = 192
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  etrs_pkg::cord_lane_t   lane_i [3],
  input  logic [PayW-1:0]        pay_i,
  output etrs_pkg::cord_lane_t   lane_o [3],
  output logic [PayW-1:0]        pay_o
);
  import etrs_pkg::*;

  localparam cord_t Atan = atan_lut(5'(Stage));

  for (genvar l = 0; l < 3; l++) begin : g_lane
    cord_t xs, ys;
    assign xs = lane_i[l].x >>> Stage;
    assign ys = lane_i[l].y >>> Stage;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        lane_o[l].q <= lane_i[l].q;
        if (!lane_i[l].z[CordW-1]) begin
          lane_o[l].x <= lane_i[l].x - ys;
          lane_o[l].y <= lane_i[l].y + xs;
          lane_o[l].z <= lane_i[l].z - Atan;
        end else begin
          lane_o[l].x <= lane_i[l].x + ys;
          lane_o[l].y <= lane_i[l].y - xs;
          lane_o[l].z <= lane_i[l].z + Atan;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pay_o <= pay_i;
    end
  end

endmodule

[design/etrs_matrix.sv]
// Matrix back end: quadrant unfold, rounding, rotation products, scaling and
// saturation over registered multiply stages. Depends on etrs_pkg.
module etrs_matrix #(
  parameter int unsigned FracBits = etrs_pkg::FracBitsDef
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  etrs_pkg::cord_lane_t        lane_i [3],
  input  logic [191:0]                pay_i,
  output logic [383:0]                res_o
);
  import etrs_pkg::*;

  localparam int unsigned Sh = 30 - FracBits;
  typedef logic signed [33:0] fx_t;
  typedef logic signed [65:0] w_t;

  function automatic fx_t to_frac(input cord_t v);
    cord_t t;
    t = v + (cord_t'(1) <<< (Sh - 1));
    return fx_t'(t >>> Sh);
  endfunction

  function automatic w_t fm(input fx_t a, input fx_t b);
    w_t t;
    t = a * b + (w_t'(1) <<< (FracBits - 1));
    return t >>> FracBits;
  endfunction

  fx_t s_q [3];
  fx_t c_q [3];
  fx_t s2_q [3];
  fx_t c2_q [3];
  logic [191:0] p1_q, p2_q, p3_q;
  w_t  a_q [8];
  w_t  r_q [9];
  logic signed [31:0] o_q [9];

  for (genvar l = 0; l < 3; l++) begin : g_unf
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        unique case (lane_i[l].q)
          2'd0: begin c_q[l] <= to_frac(lane_i[l].x);  s_q[l] <= to_frac(lane_i[l].y);  end
          2'd1: begin c_q[l] <= to_frac(-lane_i[l].y); s_q[l] <= to_frac(lane_i[l].x);  end
          2'd2: begin c_q[l] <= to_frac(-lane_i[l].x); s_q[l] <= to_frac(-lane_i[l].y); end
          default: begin c_q[l] <= to_frac(lane_i[l].y); s_q[l] <= to_frac(-lane_i[l].x); end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_q <= pay_i;
      // first products: cy*cz, cy*sz, sy*cz, sy*sz, cx*sz, cx*cz, sx*cy, cx*cy
      a_q[0] <= fm(c_q[1], c_q[2]);
      a_q[1] <= fm(c_q[1], s_q[2]);
      a_q[2] <= fm(s_q[1], c_q[2]);
      a_q[3] <= fm(s_q[1], s_q[2]);
      a_q[4] <= fm(c_q[0], s_q[2]);
      a_q[5] <= fm(c_q[0], c_q[2]);
      a_q[6] <= fm(s_q[0], c_q[1]);
      a_q[7] <= fm(c_q[0], c_q[1]);
      p2_q <= p1_q;
      r_q[0] <= a_q[0];
      r_q[1] <= -a_q[1];
      r_q[2] <= w_t'(s2_q[1]);
      r_q[3] <= a_q[4] + fm(s2_q[0], fx_t'(a_q[2]));
      r_q[4] <= a_q[5] - fm(s2_q[0], fx_t'(a_q[3]));
      r_q[5] <= -a_q[6];
      r_q[6] <= fm(s2_q[0], s2_q[2]) - fm(c2_q[0], fx_t'(a_q[2]));
      r_q[7] <= fm(s2_q[0], c2_q[2]) + fm(c2_q[0], fx_t'(a_q[3]));
      r_q[8] <= a_q[7];
      p3_q <= p2_q;
    end
  end

  // hold trig values aligned with second product stage
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_q <= s_q;
      c2_q <= c_q;
    end
  end

  for (genvar k = 0; k < 9; k++) begin : g_out
    localparam int unsigned J = k % 3;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        o_q[k] <= sat32(fm(fx_t'(r_q[k]), fx_t'($signed(p3_q[96+32*J +: 32]))));
      end
    end
    assign res_o[128*(k/3) + 32*J +: 32] = o_q[k];
  end

  logic [95:0] pos_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pos_q <= p3_q[95:0];
    end
  end
  assign res_o[96 +: 32]  = pos_q[31:0];
  assign res_o[224 +: 32] = pos_q[63:32];
  assign res_o[352 +: 32] = pos_q[95:64];

endmodule

[design/euler_trs_model_matrix.sv]
// Euler TRS model matrix, top level: reduce, CORDIC cell chain, matrix back end.
// One request per cycle is sustained while the output is free or taken.
// Throughput is one item per cycle; the pipeline advances whenever the output
// register is free or taken. Reset clears the valid bits only.
// Depends on etrs_pkg, etrs_reduce, etrs_cordic_cell, etrs_matrix.
module euler_trs_model_matrix #(
  parameter int unsigned CORDIC_STAGES = etrs_pkg::CordicStagesDef,
  parameter int unsigned FRAC_BITS     = etrs_pkg::FracBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  // pos_x, pos_y, pos_z, angle_x, angle_y, angle_z, scale_x, scale_y, scale_z
  input  logic [239:0]  s_axis_tdata_i,
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  // row0_col0..row0_col3, row1_col0..row1_col3, row2_col0..row2_col3
  output logic [383:0]  m_axis_tdata_o
);
  import etrs_pkg::*;

  localparam int unsigned Lat = CORDIC_STAGES + 6;

  logic en;
  logic [Lat-1:0] vld_q;
  logic [191:0] pay;

  assign en = !vld_q[Lat-1] || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = vld_q[Lat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], s_axis_tvalid_i};
    end
  end

  cord_lane_t   lane [CORDIC_STAGES+1][3];
  logic [191:0] pay_c [CORDIC_STAGES+1];
  logic [191:0] pay_q [2];

  assign pay = {s_axis_tdata_i[239:144], s_axis_tdata_i[95:0]};

  for (genvar l = 0; l < 3; l++) begin : g_red
    etrs_reduce u_red (
      .clk_i   (clk_i),
      .en_i    (en),
      .angle_i (s_axis_tdata_i[96+16*l +: 16]),
      .lane_o  (lane[0][l])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pay_q[0] <= pay;
      pay_q[1] <= pay_q[0];
    end
  end
  assign pay_c[0] = pay_q[1];

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    etrs_cordic_cell #(.Stage(i), .PayW(192)) u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .lane_i (lane[i]),
      .pay_i  (pay_c[i]),
      .lane_o (lane[i+1]),
      .pay_o  (pay_c[i+1])
    );
  end

  etrs_matrix #(.FracBits(FRAC_BITS)) u_mat (
    .clk_i  (clk_i),
    .en_i   (en),
    .lane_i (lane[CORDIC_STAGES]),
    .pay_i  (pay_c[CORDIC_STAGES]),
    .res_o  (m_axis_tdata_o)
  );

endmodule

[design/etrs_checker.sv]
// Port-level checker for euler_trs_model_matrix, bound to the top level.
// Depends on the top level's ports only.
module etrs_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid_i,
  input logic         s_axis_tready_o,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [383:0] m_axis_tdata_o
);
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output valid dropped");
  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("output data changed under stall");
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty output");
  a_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid_o)
    else $error("valid after reset");
endmodule

bind euler_trs_model_matrix etrs_checker u_chk (.*);

[bench/euler_trs_model_matrix_test.sv]
// Testbench for euler_trs_model_matrix: drives object transforms, predicts the
// model matrix rows with a bit-exact CORDIC and fixed-point model, and checks them.
// Depends on etrs_pkg and the euler_trs_model_matrix RTL.
module euler_trs_model_matrix_test;
  timeunit 1ns;
  timeprecision 1ps;

  import etrs_pkg::*;

  localparam int Stages = CordicStagesDef;
  localparam int Frac   = FracBitsDef;

  typedef struct packed {
    logic signed [31:0] scl_z, scl_y, scl_x;
    logic signed [15:0] ang_z, ang_y, ang_x;
    logic signed [31:0] pz, py, px;
  } xform_t;

  typedef logic [383:0] matrix_t;

  function automatic longint floor_shr(longint v, int k);
    return v >>> k;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    return floor_shr(a * b + (64'sd1 << (Frac - 1)), Frac);
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint atan_step(int i);
    longint t[30] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
                      83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
                      81, 41, 20, 10, 5, 3, 1};
    return t[i];
  endfunction

  function automatic void sin_cos(input logic signed [15:0] ang, output longint s,
                                  output longint c);
    longint m, x, y, z, nx, cc, ss;
    logic [63:0] p;
    int q;
    m = longint'(ang) % 23040;
    if (m < 0) m += 23040;
    p = (64'(m) << 32) / 64'd23040;
    q = int'(p[31:30]);
    z = longint'(p[29:0]);
    x = 652032874;
    y = 0;
    for (int i = 0; i < Stages && i < 30; i++) begin
      if (z >= 0) begin
        nx = x - floor_shr(y, i); y = y + floor_shr(x, i); z -= atan_step(i);
      end else begin
        nx = x + floor_shr(y, i); y = y - floor_shr(x, i); z += atan_step(i);
      end
      x = nx;
    end
    case (q)
      0: begin cc = x; ss = y; end
      1: begin cc = -y; ss = x; end
      2: begin cc = -x; ss = -y; end
      default: begin cc = y; ss = -x; end
    endcase
    s = floor_shr(ss + (64'sd1 << (29 - Frac)), 30 - Frac);
    c = floor_shr(cc + (64'sd1 << (29 - Frac)), 30 - Frac);
  endfunction

  function automatic matrix_t model_matrix(xform_t t);
    longint sx, cx, sy, cy, sz, cz;
    longint r[3][3], sc[3];
    longint v;
    matrix_t res;
    sin_cos(t.ang_x, sx, cx);
    sin_cos(t.ang_y, sy, cy);
    sin_cos(t.ang_z, sz, cz);
    sc[0] = t.scl_x; sc[1] = t.scl_y; sc[2] = t.scl_z;
    r[0][0] = fx_mul(cy, cz);
    r[0][1] = -fx_mul(cy, sz);
    r[0][2] = sy;
    r[1][0] = fx_mul(cx, sz) + fx_mul(sx, fx_mul(sy, cz));
    r[1][1] = fx_mul(cx, cz) - fx_mul(sx, fx_mul(sy, sz));
    r[1][2] = -fx_mul(sx, cy);
    r[2][0] = fx_mul(sx, sz) - fx_mul(cx, fx_mul(sy, cz));
    r[2][1] = fx_mul(sx, cz) + fx_mul(cx, fx_mul(sy, sz));
    r[2][2] = fx_mul(cx, cy);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        v = clamp32(fx_mul(r[i][j], sc[j]));
        res[(i*4+j)*32 +: 32] = v[31:0];
      end
    end
    res[3*32 +: 32]  = t.px;
    res[7*32 +: 32]  = t.py;
    res[11*32 +: 32] = t.pz;
    return res;
  endfunction

  int errors = 0;

  task automatic report(string what);
    $display("MISMATCH %0t: %s", $realtime, what);
    errors++;
  endtask

  class matrix_board;
    matrix_t pending[$];
    function void note_request(xform_t t);
      pending.push_back(model_matrix(t));
    endfunction
    task check_result(matrix_t got);
      matrix_t want;
      if (pending.size() == 0) begin
        report("result with nothing pending");
        return;
      end
      want = pending.pop_front();
      for (int k = 0; k < 12; k++) begin
        if (got[k*32 +: 32] !== want[k*32 +: 32])
          report($sformatf("row%0d_col%0d got %h want %h", k / 4, k % 4,
                           got[k*32 +: 32], want[k*32 +: 32]));
      end
    endtask
  endclass

  matrix_board board = new();

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [239:0] s_axis_tdata_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [383:0] m_axis_tdata_o;
  bit           hold_off = 1'b0;
  bit           sending_done = 1'b0;

  euler_trs_model_matrix dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_xform(xform_t t);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    s_axis_tdata_i <= t;
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    board.note_request(t);
    @(negedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'sh8000_0000 + $urandom_range(0, 3);
      2: return 32'sh7FFF_FFFF - $urandom_range(0, 3);
      default: return $signed($urandom_range(0, 32'h6_0000)) - 32'sh3_0000;
    endcase
  endfunction

  function automatic logic signed [15:0] rand_angle();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 7) * 5760);
      1: return 16'sh8000 + 16'($urandom_range(0, 4));
      default: return r[15:0];
    endcase
  endfunction

  function automatic xform_t rand_xform();
    xform_t t;
    t.px = $urandom; t.py = $urandom; t.pz = $urandom;
    t.ang_x = rand_angle(); t.ang_y = rand_angle(); t.ang_z = rand_angle();
    t.scl_x = rand_word(); t.scl_y = rand_word(); t.scl_z = rand_word();
    return t;
  endfunction

  function automatic xform_t make_xform(logic signed [31:0] p, logic signed [15:0] a,
                                        logic signed [31:0] s);
    xform_t t;
    t.px = p; t.py = ~p; t.pz = p ^ 32'h5A5A_A5A5;
    t.ang_x = a; t.ang_y = a + 16'sd1440; t.ang_z = -a;
    t.scl_x = s; t.scl_y = -s; t.scl_z = s >>> 1;
    return t;
  endfunction

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    send_xform(make_xform(32'sh0, 16'sd0, 32'sh0001_0000));
    send_xform(make_xform(32'sh7FFF_FFFF, 16'sd5760, 32'sh7FFF_FFFF));
    send_xform(make_xform(32'sh8000_0000, 16'sd11520, 32'sh8000_0000));
    send_xform(make_xform(32'shFFFF_FFFF, 16'sd17280, 32'shFFFF_0000));
    send_xform(make_xform(32'sh1234_5678, 16'sd23040, 32'sh0));
    send_xform(make_xform(32'sh0, -16'sd5760, 32'sh0002_8000));
    send_xform(make_xform(32'sh0, 16'sd32767, 32'sh7FFF_FFFF));
    send_xform(make_xform(32'sh0, 16'sh8000, 32'sh8000_0000));
    send_xform(make_xform(32'sh0, 16'sd2880, 32'sh4000_0000));
    send_xform(make_xform(32'sh0, 16'sd1, 32'shFFFF_FFFF));
    send_xform(make_xform(32'sh0, -16'sd1, 32'sh0000_0001));
    for (int n = 0; n < 540; n++) begin
      if (n == 200) hold_off = 1'b1;
      send_xform(rand_xform());
    end
    s_axis_tvalid_i <= 1'b0;
    sending_done = 1'b1;
  end

  initial begin
    int g;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        m_axis_tready_i <= 1'b0;
        repeat (120) @(negedge clk_i);
        hold_off = 1'b0;
      end
      g = gap_len();
      if (g > 0 && $urandom_range(0, 1)) begin
        m_axis_tready_i <= 1'b0;
        repeat (g) @(negedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      board.check_result(m_axis_tdata_o);
  end

  initial begin
    wait (sending_done);
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (Stages + 20) @(posedge clk_i);
    if (errors == 0) begin
      $display("euler_trs_model_matrix_test: clean");
    end else begin
      $display("euler_trs_model_matrix_test: errors");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("euler_trs_model_matrix_test: errors");
    $finish;
  end

endmodule
